>>> rtl/manchester_pulse_width_decoder_unit_macros.svh
// Assertion macros for the Manchester pulse width decoder.
// Needs i_clk and i_rst_n in the scope of each use; empty under SYNTHESIS.
`ifndef MANCHESTER_PULSE_WIDTH_DECODER_UNIT_MACROS_SVH
`define MANCHESTER_PULSE_WIDTH_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MPWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpwd: same-cycle check failed");
`define MPWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpwd: next-cycle check failed");
`define MPWD_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) 1'b1 |-> !(expr)) \
        else $error("mpwd: forbidden condition seen");
`else
`define MPWD_ASSERT_NOW(label, ante, cons)
`define MPWD_ASSERT_NEXT(label, ante, cons)
`define MPWD_ASSERT_NEVER(label, expr)
`endif
`endif

>>> rtl/mpwd_pkg.sv
// Shared types and constants of the Manchester pulse width decoder.
// No dependencies.
package mpwd_pkg;

    localparam int WIDTH_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BITS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_THR   = 3'd5;

    // Register reset values
    localparam logic [WIDTH_W-1:0] RST_SHORT_MIN = 16'd200;
    localparam logic [WIDTH_W-1:0] RST_LONG_MIN  = 16'd700;
    localparam logic [WIDTH_W-1:0] RST_LONG_MAX  = 16'd1400;
    localparam logic [BYTE_W-1:0]  RST_MIN_BITS  = 8'd64;
    localparam logic [BYTE_W-1:0]  RST_MAX_BITS  = 8'd128;
    localparam logic [BYTE_W-1:0]  RST_PRE_THR   = 8'd20;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    typedef enum logic [1:0] {
        OC_NONE,
        OC_ABORT,
        OC_FRAME,
        OC_EMPTY
    } t_outcome;

    typedef struct packed {
        logic step;
        logic clear;
        logic rd_en;
        logic load_abort;
        logic load_byte;
        logic emit_next;
    } t_dp_cmd;

    typedef struct packed {
        t_outcome outcome;
        logic     out_free;
        logic     emit_last;
    } t_dp_status;

endpackage

>>> rtl/mpwd_if.sv
// Channel interfaces of the Manchester pulse width decoder: pulse, result, config.
// Depends on mpwd_pkg.
interface mpwd_pulse_if;
    logic                         valid;
    logic                         ready;
    logic [mpwd_pkg::WIDTH_W-1:0] pulse_width;
    modport source (output valid, output pulse_width, input ready);
    modport sink   (input valid, input pulse_width, output ready);
endinterface

interface mpwd_result_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [mpwd_pkg::BYTE_W-1:0] frame_byte;
    logic [mpwd_pkg::BYTE_W-1:0] bit_count;
    logic                        last;
    modport source (output valid, output kind, output frame_byte, output bit_count,
                    output last, input ready);
    modport sink   (input valid, input kind, input frame_byte, input bit_count,
                    input last, output ready);
endinterface

interface mpwd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mpwd_pkg::CFG_IDX_W-1:0]  index;
    logic [mpwd_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/mpwd_ctrl.sv
// Sequencer of the Manchester pulse width decoder: steps pulses, drives emission.
// Depends on mpwd_pkg and the assertion macro header.
`include "manchester_pulse_width_decoder_unit_macros.svh"
module mpwd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mpwd_pkg::t_dp_status i_status,
    output mpwd_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ABORT,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    case (i_status.outcome)
                        mpwd_pkg::OC_ABORT: n_state = S_ABORT;
                        mpwd_pkg::OC_FRAME: n_state = S_READ;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_ABORT: begin
                if (i_status.out_free) begin
                    o_cmd.load_abort = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `MPWD_ASSERT_NOW(a_load_needs_slot, o_cmd.load_abort || o_cmd.load_byte, i_status.out_free)
    `MPWD_ASSERT_NEXT(a_frame_blocks_input,
        o_cmd.step && (i_status.outcome == mpwd_pkg::OC_FRAME), !o_in_ready)
    `MPWD_ASSERT_NEXT(a_clear_returns_idle, o_cmd.clear, o_in_ready)

endmodule

>>> rtl/mpwd_dpath.sv
// Datapath of the Manchester pulse width decoder: config registers, pulse
// classing, bit assembly, byte store and result register. Depends on mpwd_pkg.
`include "manchester_pulse_width_decoder_unit_macros.svh"
module mpwd_dpath #(
    parameter int MAX_BITS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mpwd_pkg::WIDTH_W-1:0]      i_pulse_width,
    input  logic                              i_cfg_we,
    input  logic [mpwd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpwd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  mpwd_pkg::t_dp_cmd                 i_cmd,
    output mpwd_pkg::t_dp_status              o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_kind,
    output logic [mpwd_pkg::BYTE_W-1:0]       o_frame_byte,
    output logic [mpwd_pkg::BYTE_W-1:0]       o_bit_count,
    output logic                              o_last
);

    localparam int StoreBytes = (MAX_BITS + 7) / 8;
    localparam int BW = $clog2(MAX_BITS + 1);
    localparam int AW = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
    localparam int CW = $clog2(StoreBytes + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_OK,
        PH_HALF
    } t_phase;

    // Configuration
    logic [mpwd_pkg::WIDTH_W-1:0] r_short_min, r_long_min, r_long_max;
    logic [mpwd_pkg::BYTE_W-1:0]  r_min_bits, r_max_bits, r_pre_thr;

    // Frame state
    t_phase                      r_phase, n_phase;
    logic [7:0]                  r_pre, n_pre;
    logic [BW-1:0]               r_bits, n_bits;
    logic [mpwd_pkg::BYTE_W-1:0] r_acc, n_acc;
    logic [CW-1:0]               r_emit_idx;

    logic [mpwd_pkg::BYTE_W-1:0] r_mem [StoreBytes];
    logic [mpwd_pkg::BYTE_W-1:0] r_rdata;

    logic                        r_out_valid;
    logic                        r_kind, r_last;
    logic [mpwd_pkg::BYTE_W-1:0] r_byte, r_count;

    logic                        in_range, is_long;
    logic [BW-1:0]               eff_max;
    logic                        do_store, store_v, mem_we;
    logic [mpwd_pkg::BYTE_W-1:0] acc_shift;
    logic [AW-1:0]               wr_addr;
    logic [BW-1:0]               bits_shr;
    logic [BW:0]                 n_bytes;
    logic [BW-1:0]               full_bytes;
    logic [mpwd_pkg::BYTE_W-1:0] emit_byte;
    mpwd_pkg::t_outcome          outcome;
    logic                        drop_frame;

    assign in_range = (i_pulse_width >= r_short_min) && (i_pulse_width < r_long_max);
    assign is_long  = (i_pulse_width >= r_long_min);

    always_comb begin
        if (32'(r_max_bits) > MAX_BITS) begin
            eff_max = BW'(MAX_BITS);
        end else if (r_max_bits == 8'd0) begin
            eff_max = BW'(1);
        end else begin
            eff_max = BW'(r_max_bits);
        end
    end

    assign acc_shift = {store_v, r_acc[mpwd_pkg::BYTE_W-1:1]};
    assign bits_shr  = r_bits >> 3;
    assign wr_addr   = bits_shr[AW-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_pre    = r_pre;
        n_bits   = r_bits;
        n_acc    = r_acc;
        do_store = 1'b0;
        store_v  = 1'b0;
        mem_we   = 1'b0;
        outcome  = mpwd_pkg::OC_NONE;
        if (!in_range) begin
            // gap: keep the frame if long enough, else drop it
            if ((32'(r_bits) >= 32'(r_min_bits)) && (r_bits < eff_max)) begin
                outcome = (r_bits == '0) ? mpwd_pkg::OC_EMPTY : mpwd_pkg::OC_FRAME;
            end else begin
                outcome = mpwd_pkg::OC_ABORT;
            end
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (!is_long) begin
                        if (r_pre != 8'hFF) begin
                            n_pre = r_pre + 8'd1;
                        end
                    end else if (r_pre > r_pre_thr) begin
                        // level set to one then toggled: first bit is zero
                        n_pre    = 8'd0;
                        do_store = 1'b1;
                        store_v  = 1'b0;
                    end else begin
                        outcome = mpwd_pkg::OC_ABORT;
                    end
                end
                PH_OK: begin
                    if (!is_long) begin
                        n_phase = PH_HALF;
                    end else begin
                        n_pre    = {7'd0, ~r_pre[0]};
                        do_store = 1'b1;
                        store_v  = ~r_pre[0];
                    end
                end
                PH_HALF: begin
                    if (!is_long) begin
                        do_store = 1'b1;
                        store_v  = r_pre[0];
                    end else begin
                        outcome = mpwd_pkg::OC_ABORT;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
            if (do_store) begin
                n_phase = PH_OK;
                if (32'(r_bits) < MAX_BITS) begin
                    n_acc  = acc_shift;
                    n_bits = r_bits + BW'(1);
                    if (r_bits[2:0] == 3'd7) begin
                        mem_we = 1'b1;
                        n_acc  = '0;
                    end
                end
            end
            if ((outcome == mpwd_pkg::OC_NONE) && (n_bits >= eff_max)) begin
                outcome = mpwd_pkg::OC_FRAME;
            end
        end
    end

    assign drop_frame = i_cmd.clear || (i_cmd.step &&
        ((outcome == mpwd_pkg::OC_ABORT) || (outcome == mpwd_pkg::OC_EMPTY)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min <= mpwd_pkg::RST_SHORT_MIN;
            r_long_min  <= mpwd_pkg::RST_LONG_MIN;
            r_long_max  <= mpwd_pkg::RST_LONG_MAX;
            r_min_bits  <= mpwd_pkg::RST_MIN_BITS;
            r_max_bits  <= mpwd_pkg::RST_MAX_BITS;
            r_pre_thr   <= mpwd_pkg::RST_PRE_THR;
            r_phase     <= PH_HUNT;
            r_pre       <= '0;
            r_bits      <= '0;
            r_acc       <= '0;
            r_emit_idx  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mpwd_pkg::CFG_SHORT_MIN: r_short_min <= i_cfg_data;
                    mpwd_pkg::CFG_LONG_MIN:  r_long_min  <= i_cfg_data;
                    mpwd_pkg::CFG_LONG_MAX:  r_long_max  <= i_cfg_data;
                    mpwd_pkg::CFG_MIN_BITS:  r_min_bits  <= i_cfg_data[7:0];
                    mpwd_pkg::CFG_MAX_BITS:  r_max_bits  <= i_cfg_data[7:0];
                    mpwd_pkg::CFG_PRE_THR:   r_pre_thr   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (drop_frame) begin
                r_phase    <= PH_HUNT;
                r_pre      <= '0;
                r_bits     <= '0;
                r_acc      <= '0;
                r_emit_idx <= '0;
            end else begin
                if (i_cmd.step) begin
                    r_phase <= n_phase;
                    r_pre   <= n_pre;
                    r_bits  <= n_bits;
                    r_acc   <= n_acc;
                end
                if (i_cmd.emit_next) begin
                    r_emit_idx <= r_emit_idx + CW'(1);
                end
            end
        end
    end

    // Byte store: completed bytes only, the partial byte stays in r_acc
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && mem_we) begin
            r_mem[wr_addr] <= acc_shift;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[r_emit_idx[AW-1:0]];
        end
    end

    assign n_bytes    = ({1'b0, r_bits} + (BW+1)'(7)) >> 3;
    assign full_bytes = r_bits >> 3;
    assign emit_byte  = (32'(r_emit_idx) < 32'(full_bytes)) ? r_rdata : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_abort || i_cmd.load_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_abort) begin
            r_kind  <= mpwd_pkg::KIND_ABORT;
            r_byte  <= '0;
            r_count <= '0;
            r_last  <= 1'b1;
        end else if (i_cmd.load_byte) begin
            r_kind  <= mpwd_pkg::KIND_BYTE;
            r_byte  <= emit_byte;
            r_count <= 8'(r_bits);
            r_last  <= o_status.emit_last;
        end
    end

    assign o_status.outcome   = outcome;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.emit_last = ((32'(r_emit_idx) + 32'd1) == 32'(n_bytes));

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_frame_byte = r_byte;
    assign o_bit_count  = r_count;
    assign o_last       = r_last;

    `MPWD_ASSERT_NEVER(a_bits_bounded, 32'(r_bits) > MAX_BITS)
    `MPWD_ASSERT_NEXT(a_byte_flush_empties_acc, i_cmd.step && mem_we, r_acc == '0)
    `MPWD_ASSERT_NOW(a_abort_payload, r_out_valid && (r_kind == mpwd_pkg::KIND_ABORT),
        (r_byte == '0) && (r_count == '0) && r_last)

endmodule

>>> rtl/manchester_pulse_width_decoder_unit.sv
// Top level of the Manchester pulse width decoder.
// Depends on mpwd_pkg, mpwd_if.sv, mpwd_ctrl and mpwd_dpath.
//
//   channel    dir  payload                                  request taken when
//   i_pulse    in   pulse_width[15:0]                        valid && ready
//   i_cfg      in   index[2:0], data[15:0]                   valid && ready (ready tied high)
//   o_result   out  kind, frame_byte[7:0], bit_count[7:0],   valid && ready
//                   last
//
// A pulse that yields no result leaves the sequencer idle. An abort passes through
// S_ABORT before the next pulse is taken; a completed frame passes S_READ then S_LOAD
// per byte, set by the registered read of the byte store (one address, then one byte out).
// The byte store needs no clearing pass: only bytes written in the current frame
// are read back. Synchronous active-low reset restores register defaults.
// A stalled result holds in the output register; pulses that yield nothing are
// still taken meanwhile, and the sequencer waits only when it needs that slot.
module manchester_pulse_width_decoder_unit #(
    parameter int MAX_BITS = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mpwd_pulse_if.sink           i_pulse,
    mpwd_cfg_if.sink             i_cfg,
    mpwd_result_if.source        o_result
);

    mpwd_pkg::t_dp_cmd    cmd;
    mpwd_pkg::t_dp_status status;

    // Registers accept a write in any cycle
    assign i_cfg.ready = 1'b1;

    mpwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pulse.valid),
        .o_in_ready (i_pulse.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mpwd_dpath #(
        .MAX_BITS (MAX_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pulse_width (i_pulse.pulse_width),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_kind        (o_result.kind),
        .o_frame_byte  (o_result.frame_byte),
        .o_bit_count   (o_result.bit_count),
        .o_last        (o_result.last)
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for manchester_pulse_width_decoder_unit: programs the thresholds,
// streams pulse widths and checks every frame byte and abort against its own decoder.
// Depends on mpwd_pkg, the channel interfaces of mpwd_if.sv and the decoder RTL.
module testbench;

    localparam int DEC_MAX_BITS  = 128;
    localparam int STORE_BYTES   = (DEC_MAX_BITS + 7) / 8;
    localparam int STORE_AW      = $clog2(STORE_BYTES);
    localparam int RST_CYCLES    = 6;
    // worst frame reads out all sixteen store bytes after its last pulse; leave some margin
    localparam int SETTLE_CYCLES = 40;
    localparam int WDOG_LIMIT    = 5000;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BOUNDARY,
        PH_HALF,
        PH_SPARE
    } t_phase;

    typedef struct packed {
        logic [15:0] short_floor;
        logic [15:0] long_floor;
        logic [15:0] gap_floor;
        logic [7:0]  min_bits;
        logic [7:0]  max_bits;
        logic [7:0]  pre_thr;
    } t_dec_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_byte;
        logic [7:0] bit_count;
        logic       last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpwd_pulse_if  pulse_ch ();
    mpwd_cfg_if    cfg_ch ();
    mpwd_result_if result_ch ();

    manchester_pulse_width_decoder_unit #(
        .MAX_BITS (DEC_MAX_BITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pulse  (pulse_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder prediction: register copy, frame state and awaited results
    // ------------------------------------------------------------------
    t_dec_cfg   dec_cfg;
    t_phase     dec_phase;
    logic [7:0] dec_level;      // preamble count while hunting, Manchester level after
    logic [7:0] dec_bits;
    logic [7:0] dec_store [STORE_BYTES];
    t_result    awaited_results [$];

    // Clamp the bit limit into [1, DEC_MAX_BITS].
    function automatic logic [7:0] bit_limit(logic [7:0] max_bits);
        if (max_bits == 8'd0) return 8'd1;
        if (max_bits > DEC_MAX_BITS) return 8'(DEC_MAX_BITS);
        return max_bits;
    endfunction

    function automatic void clear_frame();
        dec_phase = PH_HUNT;
        dec_level = '0;
        dec_bits  = '0;
        foreach (dec_store[k]) dec_store[k] = '0;
    endfunction

    // Shift the new bit in at the top of its byte, then sit on a bit boundary.
    function automatic void store_bit(logic b);
        if (dec_bits < DEC_MAX_BITS) begin
            dec_store[dec_bits[STORE_AW+2:3]] = {b, dec_store[dec_bits[STORE_AW+2:3]][7:1]};
            dec_bits = dec_bits + 8'd1;
        end
        dec_phase = PH_BOUNDARY;
    endfunction

    // Queue one byte per started octet; an empty frame queues nothing but still clears.
    function automatic void emit_frame();
        t_result r;
        int      n;
        int      k;
        n = (int'(dec_bits) + 7) / 8;
        for (k = 0; k < n; k++) begin
            r.kind       = mpwd_pkg::KIND_BYTE;
            r.frame_byte = dec_store[STORE_AW'(k)];
            r.bit_count  = dec_bits;
            r.last       = (k == n - 1);
            awaited_results.push_back(r);
        end
        clear_frame();
    endfunction

    function automatic void emit_abort();
        t_result r;
        r.kind       = mpwd_pkg::KIND_ABORT;
        r.frame_byte = '0;
        r.bit_count  = '0;
        r.last       = 1'b1;
        awaited_results.push_back(r);
        clear_frame();
    endfunction

    // Advance the decoder by one accepted pulse width.
    function automatic void decode_pulse(logic [15:0] w);
        logic is_long;
        // out-of-range width: complete if enough bits are held, else abort
        if (!(w >= dec_cfg.short_floor && w < dec_cfg.gap_floor)) begin
            if (dec_bits >= dec_cfg.min_bits && dec_bits < bit_limit(dec_cfg.max_bits))
                emit_frame();
            else
                emit_abort();
            return;
        end
        is_long = (w >= dec_cfg.long_floor);
        case (dec_phase)
            PH_HUNT: begin
                if (!is_long) begin
                    if (dec_level != 8'hFF) dec_level = dec_level + 8'd1;
                end else if (dec_level > dec_cfg.pre_thr) begin
                    // level starts high and the long half toggles it: a zero bit
                    dec_level = 8'd0;
                    store_bit(1'b0);
                end else begin
                    emit_abort();
                    return;
                end
            end
            PH_BOUNDARY: begin
                if (!is_long) begin
                    dec_phase = PH_HALF;
                end else begin
                    dec_level = dec_level ^ 8'd1;
                    store_bit(dec_level[0]);
                end
            end
            PH_HALF: begin
                if (!is_long) begin
                    store_bit(dec_level[0]);
                end else begin
                    emit_abort();
                    return;
                end
            end
            default: dec_phase = PH_HUNT;
        endcase
        // completion at the bit limit is checked before anything could overflow
        if (dec_bits >= bit_limit(dec_cfg.max_bits)) emit_frame();
    endfunction

    // Mirror every accepted register write into the predictor's copy.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_cfg = '{mpwd_pkg::RST_SHORT_MIN, mpwd_pkg::RST_LONG_MIN,
                        mpwd_pkg::RST_LONG_MAX, mpwd_pkg::RST_MIN_BITS,
                        mpwd_pkg::RST_MAX_BITS, mpwd_pkg::RST_PRE_THR};
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                mpwd_pkg::CFG_SHORT_MIN: dec_cfg.short_floor = cfg_ch.data;
                mpwd_pkg::CFG_LONG_MIN:  dec_cfg.long_floor  = cfg_ch.data;
                mpwd_pkg::CFG_LONG_MAX:  dec_cfg.gap_floor   = cfg_ch.data;
                mpwd_pkg::CFG_MIN_BITS:  dec_cfg.min_bits    = cfg_ch.data[7:0];
                mpwd_pkg::CFG_MAX_BITS:  dec_cfg.max_bits    = cfg_ch.data[7:0];
                mpwd_pkg::CFG_PRE_THR:   dec_cfg.pre_thr     = cfg_ch.data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pulse driver: feed requests from the backlog, idling at random
    // ------------------------------------------------------------------
    logic [15:0] pulse_backlog [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          n_pulses = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pulse_ch.valid       <= 1'b0;
            pulse_ch.pulse_width <= '0;
            clear_frame();
        end else begin
            if (pulse_ch.valid && pulse_ch.ready) begin
                decode_pulse(pulse_ch.pulse_width);
                n_pulses++;
            end
            // hold a request that is not yet taken; otherwise offer the next one
            if (!pulse_ch.valid || pulse_ch.ready) begin
                if (pulse_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pulse_ch.valid       <= 1'b1;
                    pulse_ch.pulse_width <= pulse_backlog.pop_front();
                end else begin
                    pulse_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stall at random, compare against the oldest awaited result
    // ------------------------------------------------------------------
    int n_bytes  = 0;
    int n_frames = 0;
    int n_aborts = 0;
    int n_errors = 0;

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got = {result_ch.kind, result_ch.frame_byte, result_ch.bit_count,
                       result_ch.last};
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing awaited, expected none, got %h",
                             $time, got);
                    n_errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", int'(want.kind), int'(got.kind));
                    check_field("frame_byte", int'(want.frame_byte), int'(got.frame_byte));
                    check_field("bit_count", int'(want.bit_count), int'(got.bit_count));
                    check_field("last", int'(want.last), int'(got.last));
                end
                if (got.kind == mpwd_pkg::KIND_ABORT) begin
                    n_aborts++;
                end else begin
                    n_bytes++;
                    if (got.last) n_frames++;
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run once no request of any kind has moved for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (pulse_ch.valid && pulse_ch.ready)
                || (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, WDOG_LIMIT);
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation, shaped by the register setting now in force
    // ------------------------------------------------------------------
    t_dec_cfg plan;
    int       queued = 0;
    int       n_settings = 0;

    function automatic void push_pulse(int w);
        pulse_backlog.push_back(16'(w));
        queued++;
    endfunction

    function automatic bit plan_sane();
        return plan.short_floor < plan.long_floor && plan.long_floor < plan.gap_floor;
    endfunction

    function automatic int short_width();
        return $urandom_range(plan.short_floor, int'(plan.long_floor) - 1);
    endfunction

    function automatic int long_width();
        return $urandom_range(plan.long_floor, int'(plan.gap_floor) - 1);
    endfunction

    function automatic int gap_width();
        if (plan.short_floor != 0 && $urandom_range(0, 1))
            return $urandom_range(0, int'(plan.short_floor) - 1);
        return $urandom_range(plan.gap_floor, 65535);
    endfunction

    // Queue a preamble, a start and random Manchester bits; end the frame at the
    // bit limit, at a gap, or break it on purpose.
    function automatic void add_frame(bit full_length);
        int limit;
        int target;
        int n_pre;
        int ending;
        int b;
        limit  = int'(bit_limit(plan.max_bits));
        n_pre  = int'(plan.pre_thr) + 1 + $urandom_range(0, 3);
        ending = $urandom_range(0, 9);
        if (full_length || ending < 4 || plan.min_bits >= limit)
            target = limit;
        else if (ending < 8)
            target = $urandom_range(plan.min_bits, limit - 1);
        else
            target = $urandom_range(1, limit);
        if (target < 1) target = 1;
        repeat (n_pre) push_pulse(short_width());
        push_pulse(long_width());
        for (b = 1; b < target; b++) begin
            if ($urandom_range(0, 1)) begin
                push_pulse(long_width());
            end else begin
                push_pulse(short_width());
                push_pulse(short_width());
            end
        end
        if (target < limit) begin
            if (ending >= 8 && $urandom_range(0, 1)) begin
                // a long pulse after a half bit breaks the frame
                push_pulse(short_width());
                push_pulse(long_width());
            end else begin
                if ($urandom_range(0, 3) == 0) push_pulse(short_width());
                push_pulse(gap_width());
            end
        end
    endfunction

    // Queue loose pulses: full-range widths, threshold edges, short preambles.
    function automatic void add_noise();
        int n;
        case ($urandom_range(0, 4))
            0: push_pulse($urandom_range(0, 65535));
            1: push_pulse($urandom_range(0, 1) ? 0 : 65535);
            2: begin
                case ($urandom_range(0, 5))
                    0: n = int'(plan.short_floor) - 1;
                    1: n = int'(plan.short_floor);
                    2: n = int'(plan.long_floor) - 1;
                    3: n = int'(plan.long_floor);
                    4: n = int'(plan.gap_floor) - 1;
                    default: n = int'(plan.gap_floor);
                endcase
                push_pulse(n < 0 ? 0 : n);
            end
            3: begin
                if (plan_sane() && plan.pre_thr <= 8) begin
                    // too little preamble before the long pulse
                    repeat ($urandom_range(0, plan.pre_thr)) push_pulse(short_width());
                    push_pulse(long_width());
                end else begin
                    push_pulse($urandom_range(0, 65535));
                end
            end
            default: begin
                if (plan_sane())
                    push_pulse($urandom_range(0, 1) ? short_width() : long_width());
                else
                    push_pulse($urandom_range(0, 65535));
            end
        endcase
    endfunction

    task automatic gen_random(int budget);
        int start;
        start = queued;
        while (queued - start < budget) begin
            if (plan_sane() && $urandom_range(0, 3) != 0) add_frame(1'b0);
            else add_noise();
        end
    endtask

    task automatic write_reg(logic [mpwd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(t_dec_cfg c);
        plan = c;
        n_settings++;
        write_reg(mpwd_pkg::CFG_SHORT_MIN, c.short_floor);
        write_reg(mpwd_pkg::CFG_LONG_MIN, c.long_floor);
        write_reg(mpwd_pkg::CFG_LONG_MAX, c.gap_floor);
        write_reg(mpwd_pkg::CFG_MIN_BITS, {8'd0, c.min_bits});
        write_reg(mpwd_pkg::CFG_MAX_BITS, {8'd0, c.max_bits});
        write_reg(mpwd_pkg::CFG_PRE_THR, {8'd0, c.pre_thr});
    endtask

    // Wait on the falling edge, where every request and prediction has settled,
    // until the backlog and the awaited results are empty; then let a frame flush.
    task automatic drain();
        do @(negedge i_clk);
        while (pulse_backlog.size() != 0 || pulse_ch.valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(t_dec_cfg c, int budget);
        set_config(c);
        gen_random(budget);
        drain();
    endtask

    // Directed pulses under 200/700/1400, two to twelve bits, preamble above one:
    // gaps and a premature long, a start cut short by a gap, a long after a half
    // bit, then a three-bit frame closed by a gap just under the short minimum.
    logic [15:0] directed_widths [$] = '{
        16'd0, 16'd65535, 16'd700,
        16'd200, 16'd699, 16'd1399, 16'd1400,
        16'd200, 16'd200, 16'd1000, 16'd300, 16'd900,
        16'd200, 16'd300, 16'd800, 16'd900, 16'd250, 16'd260, 16'd199
    };

    initial begin
        i_rst_n      <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= mpwd_pkg::CFG_SHORT_MIN;
        cfg_ch.data  <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // slow receiver, lively sender
        send_idle_pct = 12;
        recv_idle_pct = 85;
        set_config('{16'd200, 16'd700, 16'd1400, 8'd2, 8'd12, 8'd1});
        foreach (directed_widths[k]) push_pulse(directed_widths[k]);
        drain();
        // one-bit frames, a single short pulse of preamble suffices, gaps while hunting complete empty frames
        run_phase('{16'd200, 16'd700, 16'd1400, 8'd0, 8'd1, 8'd0}, 40);
        run_phase('{16'd100, 16'd300, 16'd600, 8'd4, 8'd40, 8'd3}, 30);

        // slow sender, lively receiver
        send_idle_pct = 85;
        recv_idle_pct = 12;
        // widest windows: a preamble well past the threshold before the start pulse
        set_config('{16'd0, 16'd1, 16'd65535, 8'd8, 8'd16, 8'd30});
        repeat (8) push_pulse(short_width());
        add_frame(1'b0);
        drain();
        // nothing is in range: every pulse is a gap and aborts
        run_phase('{16'd65535, 16'd65535, 16'd0, 8'd128, 8'd128, 8'd0}, 15);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase('{16'd50, 16'd60, 16'd70, 8'd16, 8'd32, 8'd1}, 30);
        // a full-length frame of sixteen bytes
        set_config('{16'd200, 16'd700, 16'd1400, 8'd64, 8'd128, 8'd2});
        add_frame(1'b1);
        drain();

        $display("covered %0d pulses over %0d register settings", n_pulses, n_settings);
        $display("returned %0d frame bytes in %0d frames and %0d aborts, %0d mismatches",
                 n_bytes, n_frames, n_aborts, n_errors);
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mpwd_pkg.sv
rtl/mpwd_if.sv
rtl/mpwd_ctrl.sv
rtl/mpwd_dpath.sv
rtl/manchester_pulse_width_decoder_unit.sv
tb/sv/testbench.sv
